### rtl/core/timestamp_ordered_request_queue_defines.svh
// Assertion macros for the timestamp-ordered request queue checker.
`ifndef TIMESTAMP_ORDERED_REQUEST_QUEUE_DEFINES_SVH
`define TIMESTAMP_ORDERED_REQUEST_QUEUE_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define TROQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define TROQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/troq_pkg.sv
// Shared types and codes of the timestamp-ordered request queue.
package troq_pkg;

	localparam logic [1:0] CMD_PUSH   = 2'd0;
	localparam logic [1:0] CMD_POP    = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam logic REG_OWN_RANK = 1'b0;
	localparam logic REG_WINDOW   = 1'b1;

	localparam int RANK_BITS   = 8;
	localparam int WINDOW_BITS = 5;
	localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 5'd1;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] req_ts;
		logic [7:0]  req_src;
		logic [31:0] req_data;
	} req_t;

	typedef struct packed {
		logic [1:0]  op_status;
		logic        head_valid;
		logic [31:0] head_ts;
		logic [7:0]  head_src;
		logic [31:0] head_data;
		logic [4:0]  occupancy;
		logic        is_candidate;
	} rsp_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic exec;
		logic rot;
		logic capture;
	} ctl_t;

	// Datapath to controller status
	typedef struct packed {
		logic is_remove;
		logic empty;
		logic iter_last;
	} stat_t;

endpackage

### rtl/core/timestamp_ordered_request_queue.sv
// Top level of the timestamp-ordered request queue with its register port.
// An item is taken when start is high and busy low. It passes the execute
// state, then, for a remove on a non-empty queue, a scan state in which
// compaction rotates the queue one entry a cycle through its head cell, and
// the report state. rsp holds the result from the single cycle in which done
// is high, which cannot be held off, to the next report; the next item may
// start in that same cycle. own_rank lies at address 0 and window_size at 4.
module timestamp_ordered_request_queue #(
	parameter int QUEUE_DEPTH = 16,
	parameter int STAMP_BITS  = 32,
	parameter int SOURCE_BITS = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  troq_pkg::req_t  req,
	output logic            done,
	output troq_pkg::rsp_t  rsp,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [2:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready
);

	logic [troq_pkg::RANK_BITS-1:0]   own_rank_q;
	logic [troq_pkg::WINDOW_BITS-1:0] window_q;
	troq_pkg::ctl_t                   ctl;
	troq_pkg::stat_t                  stat;

	assign pready = 1'b1;

	// Write the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_rank_q <= '0;
			window_q   <= troq_pkg::WINDOW_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == troq_pkg::REG_OWN_RANK) own_rank_q <= pwdata[7:0];
			else window_q <= pwdata[4:0];
		end
	end

	// Read back the selected register
	always_comb begin
		if (paddr[2] == troq_pkg::REG_WINDOW) prdata = {27'd0, window_q};
		else prdata = {24'd0, own_rank_q};
	end

	troq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.stat   (stat),
		.ctl    (ctl)
	);

	troq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.STAMP_BITS  (STAMP_BITS),
		.SOURCE_BITS (SOURCE_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.stat        (stat),
		.req         (req),
		.own_rank    (own_rank_q),
		.window_size (window_q),
		.rsp         (rsp)
	);

endmodule

### rtl/core/troq_ctrl.sv
// Sequencer of the request queue: accept, execute, compaction scan, report.
module troq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output logic             done,
	input  troq_pkg::stat_t  stat,
	output troq_pkg::ctl_t   ctl
);

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN, S_REPORT} state_t;

	state_t state_q;
	logic   done_q;

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	// Decode commands from the state
	always_comb begin
		ctl.load    = (state_q == S_IDLE) && start;
		ctl.exec    = (state_q == S_EXEC);
		ctl.rot     = (state_q == S_SCAN);
		ctl.capture = (state_q == S_REPORT);
	end

	// Advance the sequence and raise the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (stat.is_remove && !stat.empty) state_q <= S_SCAN;
					else state_q <= S_REPORT;
				end
				S_SCAN: begin
					if (stat.iter_last) state_q <= S_REPORT;
				end
				S_REPORT: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/core/troq_datapath.sv
// Row of sorted queue cells with insert, shift, rotate and report logic.
module troq_datapath #(
	parameter int QUEUE_DEPTH = 16,
	parameter int STAMP_BITS  = 32,
	parameter int SOURCE_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  troq_pkg::ctl_t                      ctl,
	output troq_pkg::stat_t                     stat,
	input  troq_pkg::req_t                      req,
	input  logic [troq_pkg::RANK_BITS-1:0]      own_rank,
	input  logic [troq_pkg::WINDOW_BITS-1:0]    window_size,
	output troq_pkg::rsp_t                      rsp
);

	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
	localparam int CMPW = (SOURCE_BITS > troq_pkg::RANK_BITS) ? SOURCE_BITS
		: troq_pkg::RANK_BITS;

	logic [STAMP_BITS-1:0]  ts_q   [QUEUE_DEPTH];
	logic [SOURCE_BITS-1:0] src_q  [QUEUE_DEPTH];
	logic [31:0]            data_q [QUEUE_DEPTH];
	logic [CNTW-1:0]        count_q;
	logic [CNTW-1:0]        iter_q;
	logic [1:0]             cmd_q;
	logic [STAMP_BITS-1:0]  new_ts_q;
	logic [SOURCE_BITS-1:0] new_src_q;
	logic [31:0]            new_data_q;
	logic [1:0]             status_q;
	troq_pkg::rsp_t         rsp_q;

	logic [QUEUE_DEPTH-1:0] valid;
	logic [QUEUE_DEPTH-1:0] lt;
	logic [QUEUE_DEPTH-1:0] hit;
	logic                   full;
	logic                   empty;
	logic                   keep_head;
	logic [CNTW-1:0]        last_idx;

	assign full      = (count_q >= CNTW'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign keep_head = (src_q[0] != new_src_q);
	assign last_idx  = CNTW'(count_q - CNTW'(1));

	assign stat.is_remove = (cmd_q == troq_pkg::CMD_REMOVE);
	assign stat.empty     = empty;
	assign stat.iter_last = (iter_q == CNTW'(1));

	assign rsp = rsp_q;

	// Per-cell order compare, candidate match and update
	for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
		logic [STAMP_BITS-1:0]  prev_ts, next_ts;
		logic [SOURCE_BITS-1:0] prev_src, next_src;
		logic [31:0]            prev_data, next_data;
		logic                   ins_here;

		assign valid[k] = (count_q > CNTW'(k));
		assign lt[k]    = valid[k] && ((ts_q[k] < new_ts_q) ||
			((ts_q[k] == new_ts_q) && (src_q[k] < new_src_q)));
		assign hit[k]   = valid[k] && ({27'd0, window_size} > 32'(k)) &&
			(CMPW'(src_q[k]) == CMPW'(own_rank));

		if (k == 0) begin : g_first
			assign prev_ts   = ts_q[k];
			assign prev_src  = src_q[k];
			assign prev_data = data_q[k];
			assign ins_here  = !lt[k];
		end else begin : g_rest
			assign prev_ts   = ts_q[k-1];
			assign prev_src  = src_q[k-1];
			assign prev_data = data_q[k-1];
			assign ins_here  = !lt[k] && lt[k-1];
		end

		if (k == QUEUE_DEPTH - 1) begin : g_last
			assign next_ts   = ts_q[k];
			assign next_src  = src_q[k];
			assign next_data = data_q[k];
		end else begin : g_inner
			assign next_ts   = ts_q[k+1];
			assign next_src  = src_q[k+1];
			assign next_data = data_q[k+1];
		end

		// Insert, shift down, or rotate the head to the tail unless a remove drops it
		always_ff @(posedge clk) begin
			if (ctl.exec) begin
				if (cmd_q == troq_pkg::CMD_PUSH && !full && !lt[k]) begin
					ts_q[k]   <= ins_here ? new_ts_q : prev_ts;
					src_q[k]  <= ins_here ? new_src_q : prev_src;
					data_q[k] <= ins_here ? new_data_q : prev_data;
				end else if (cmd_q == troq_pkg::CMD_POP && !empty) begin
					ts_q[k]   <= next_ts;
					src_q[k]  <= next_src;
					data_q[k] <= next_data;
				end
			end else if (ctl.rot) begin
				if (keep_head && last_idx == CNTW'(k)) begin
					ts_q[k]   <= ts_q[0];
					src_q[k]  <= src_q[0];
					data_q[k] <= data_q[0];
				end else begin
					ts_q[k]   <= next_ts;
					src_q[k]  <= next_src;
					data_q[k] <= next_data;
				end
			end
		end
	end

	// Latch the accepted item
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q      <= req.cmd;
			new_ts_q   <= STAMP_BITS'(req.req_ts);
			new_src_q  <= SOURCE_BITS'(req.req_src);
			new_data_q <= req.req_data;
		end
	end

	// Track occupancy, scan count and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			iter_q   <= '0;
			status_q <= troq_pkg::ST_DONE;
		end else if (ctl.exec) begin
			status_q <= troq_pkg::ST_DONE;
			iter_q   <= count_q;
			case (cmd_q)
				troq_pkg::CMD_PUSH: begin
					if (full) status_q <= troq_pkg::ST_FULL;
					else count_q <= CNTW'(count_q + CNTW'(1));
				end
				troq_pkg::CMD_POP: begin
					if (empty) status_q <= troq_pkg::ST_EMPTY;
					else count_q <= last_idx;
				end
				default: ;
			endcase
		end else if (ctl.rot) begin
			iter_q <= CNTW'(iter_q - CNTW'(1));
			if (!keep_head) count_q <= last_idx;
		end
	end

	// Capture the result from the updated queue
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			rsp_q.op_status    <= status_q;
			rsp_q.head_valid   <= !empty;
			rsp_q.head_ts      <= empty ? 32'd0 : 32'(ts_q[0]);
			rsp_q.head_src     <= empty ? 8'd0 : 8'(src_q[0]);
			rsp_q.head_data    <= empty ? 32'd0 : data_q[0];
			rsp_q.occupancy    <= 5'(count_q);
			rsp_q.is_candidate <= |hit;
		end
	end

endmodule

### rtl/core/troq_checker.sv
// Port-level checks of the request queue and their binding to the top level.
`include "timestamp_ordered_request_queue_defines.svh"

module troq_checker #(
	parameter int QUEUE_DEPTH = 16
) (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input troq_pkg::rsp_t rsp
);

	`TROQ_ASSERT_SAME(a_done_idle, clk, arst_n, done, !busy, "strobe while busy")
	`TROQ_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy && !done, "item not taken")
	`TROQ_ASSERT_SAME(a_head_occ, clk, arst_n, done, rsp.head_valid == (rsp.occupancy != 5'd0), "head valid mismatch")
	`TROQ_ASSERT_SAME(a_full_occ, clk, arst_n, done && rsp.op_status == troq_pkg::ST_FULL, rsp.occupancy == 5'(QUEUE_DEPTH), "full drop below depth")
	`TROQ_ASSERT_SAME(a_empty_head, clk, arst_n, done && !rsp.head_valid, rsp.head_ts == 32'd0 && rsp.head_src == 8'd0 && !rsp.is_candidate, "empty head not clear")

endmodule

bind timestamp_ordered_request_queue troq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

### tb/tb.sv
// Testbench for the timestamp-ordered request queue: directed and random items.
`timescale 1ns / 100ps

module tb;

	localparam int DEPTH = 16;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	troq_pkg::req_t    req = '0;
	logic              done;
	troq_pkg::rsp_t    rsp;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [2:0]        paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	timestamp_ordered_request_queue dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the queue contents and registers
	logic [31:0] q_ts [DEPTH];
	logic [7:0]  q_src [DEPTH];
	logic [31:0] q_data [DEPTH];
	int          q_fill;
	logic [7:0]  rank_reg;
	logic [4:0]  window_reg;

	troq_pkg::rsp_t expected_rsp [$];
	int   errors;
	int   items_sent;
	int   pushes, pops, removes, fulls, empties;

	// apply one item to the shadow queue and return the report it should give
	function automatic troq_pkg::rsp_t predict_report(troq_pkg::req_t it);
		troq_pkg::rsp_t r;
		int pos, wr;
		r = '0;
		r.op_status = troq_pkg::ST_DONE;
		case (it.cmd)
			troq_pkg::CMD_PUSH: begin
				if (q_fill >= DEPTH) begin
					r.op_status = troq_pkg::ST_FULL;
				end else begin
					pos = 0;
					while (pos < q_fill && (q_ts[pos] < it.req_ts ||
						(q_ts[pos] == it.req_ts && q_src[pos] < it.req_src)))
						pos++;
					for (int k = q_fill; k > pos; k--) begin
						q_ts[k] = q_ts[k-1];
						q_src[k] = q_src[k-1];
						q_data[k] = q_data[k-1];
					end
					q_ts[pos] = it.req_ts;
					q_src[pos] = it.req_src;
					q_data[pos] = it.req_data;
					q_fill++;
				end
			end
			troq_pkg::CMD_POP: begin
				if (q_fill == 0) begin
					r.op_status = troq_pkg::ST_EMPTY;
				end else begin
					for (int k = 1; k < q_fill; k++) begin
						q_ts[k-1] = q_ts[k];
						q_src[k-1] = q_src[k];
						q_data[k-1] = q_data[k];
					end
					q_fill--;
				end
			end
			troq_pkg::CMD_REMOVE: begin
				wr = 0;
				for (int k = 0; k < q_fill; k++) begin
					if (q_src[k] != it.req_src) begin
						q_ts[wr] = q_ts[k];
						q_src[wr] = q_src[k];
						q_data[wr] = q_data[k];
						wr++;
					end
				end
				q_fill = wr;
			end
			default: ;
		endcase
		if (q_fill > 0) begin
			r.head_valid = 1'b1;
			r.head_ts = q_ts[0];
			r.head_src = q_src[0];
			r.head_data = q_data[0];
		end
		r.occupancy = q_fill[4:0];
		for (int k = 0; k < q_fill && k < window_reg; k++)
			if (q_src[k] == rank_reg)
				r.is_candidate = 1'b1;
		return r;
	endfunction

	// check each report against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_rsp.size() == 0) begin
				$display("%0t: unexpected report %h", $time, rsp);
				errors++;
			end else begin
				troq_pkg::rsp_t e;
				e = expected_rsp.pop_front();
				if (rsp.op_status !== e.op_status)
					$display("%0t: op_status exp %0d got %0d", $time,
						e.op_status, rsp.op_status);
				if (rsp.head_valid !== e.head_valid)
					$display("%0t: head_valid exp %0d got %0d", $time,
						e.head_valid, rsp.head_valid);
				if (rsp.head_ts !== e.head_ts)
					$display("%0t: head_ts exp %h got %h", $time, e.head_ts, rsp.head_ts);
				if (rsp.head_src !== e.head_src)
					$display("%0t: head_src exp %h got %h", $time, e.head_src, rsp.head_src);
				if (rsp.head_data !== e.head_data)
					$display("%0t: head_data exp %h got %h", $time,
						e.head_data, rsp.head_data);
				if (rsp.occupancy !== e.occupancy)
					$display("%0t: occupancy exp %0d got %0d", $time,
						e.occupancy, rsp.occupancy);
				if (rsp.is_candidate !== e.is_candidate)
					$display("%0t: is_candidate exp %0d got %0d", $time,
						e.is_candidate, rsp.is_candidate);
				if (rsp !== e)
					errors++;
			end
		end
	end

	// send one item after a random gap, hold until accepted
	task automatic send_item(input logic [1:0] cmd, input logic [31:0] ts,
		input logic [7:0] src, input logic [31:0] data);
		troq_pkg::req_t it;
		int gap;
		gap = $urandom_range(0, 10);
		it.cmd = cmd;
		it.req_ts = ts;
		it.req_src = src;
		it.req_data = data;
		repeat (gap + 1) @(posedge clk);
		start <= 1'b1;
		req <= it;
		do @(posedge clk); while (busy);
		expected_rsp.push_back(predict_report(it));
		items_sent++;
		case (cmd)
			troq_pkg::CMD_PUSH: pushes++;
			troq_pkg::CMD_POP: pops++;
			troq_pkg::CMD_REMOVE: removes++;
			default: ;
		endcase
		if (expected_rsp[$].op_status == troq_pkg::ST_FULL) fulls++;
		if (expected_rsp[$].op_status == troq_pkg::ST_EMPTY) empties++;
		start <= 1'b0;
	endtask

	// wait for outstanding reports plus the longest remove latency
	task automatic drain;
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr[2] == troq_pkg::REG_OWN_RANK) rank_reg = value[7:0];
		else window_reg = value[4:0];
	endtask

	task automatic set_config(input logic [7:0] rank, input logic [4:0] window);
		drain();
		write_reg({1'b0, troq_pkg::REG_OWN_RANK, 2'b00}, {24'h0, rank});
		write_reg({1'b0, troq_pkg::REG_WINDOW, 2'b00}, {27'h0, window});
	endtask

	task automatic test_directed;
		send_item(troq_pkg::CMD_POP, 32'h0, 8'h0, 32'h0);
		send_item(troq_pkg::CMD_REMOVE, 32'h0, 8'h5, 32'h0);
		send_item(CMD_UNUSED, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
		send_item(troq_pkg::CMD_PUSH, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
		send_item(troq_pkg::CMD_PUSH, 32'h0, 8'h0, 32'h0);
		send_item(troq_pkg::CMD_PUSH, 32'h10, 8'h3, 32'hA5A5_A5A5);
		send_item(troq_pkg::CMD_PUSH, 32'h10, 8'h3, 32'h5A5A_5A5A);
		send_item(troq_pkg::CMD_PUSH, 32'h10, 8'h1, 32'h1234_5678);
		// fill to the top, then overflow three times
		for (int i = 0; i < 13; i++)
			send_item(troq_pkg::CMD_PUSH, $urandom_range(0, 40),
				8'($urandom_range(0, 7)), $urandom);
		send_item(troq_pkg::CMD_PUSH, 32'h1, 8'h1, 32'h1);
		send_item(troq_pkg::CMD_REMOVE, 32'h0, 8'h9, 32'h0);
		send_item(troq_pkg::CMD_REMOVE, 32'h0, 8'h3, 32'h0);
		send_item(troq_pkg::CMD_POP, 32'h0, 8'h0, 32'h0);
	endtask

	task automatic test_configs;
		set_config(8'h0, 5'd0);
		send_item(troq_pkg::CMD_PUSH, 32'h5, 8'h0, 32'h7);
		set_config(8'hFF, 5'd16);
		send_item(troq_pkg::CMD_PUSH, 32'h6, 8'hFF, 32'h8);
		send_item(troq_pkg::CMD_REMOVE, 32'h0, 8'hFF, 32'h0);
		set_config(8'h3, 5'd31);
		send_item(troq_pkg::CMD_PUSH, 32'h2, 8'h3, 32'h9);
	endtask

	task automatic test_random(input int n);
		int r;
		logic [7:0] src;
		logic [31:0] ts;
		for (int i = 0; i < n; i++) begin
			if (i % 300 == 299)
				set_config(8'($urandom_range(0, 7)), 5'($urandom_range(0, 16)));
			r = $urandom_range(0, 99);
			// small source and stamp pools force ties; full range keeps every bit busy
			src = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
			ts = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 31);
			if (r < 50)
				send_item(troq_pkg::CMD_PUSH, ts, src, $urandom);
			else if (r < 75)
				send_item(troq_pkg::CMD_POP, $urandom, src, $urandom);
			else if (r < 95)
				send_item(troq_pkg::CMD_REMOVE, $urandom, src, $urandom);
			else
				send_item(CMD_UNUSED, $urandom, src, $urandom);
		end
	endtask

	initial begin
		errors = 0;
		items_sent = 0;
		pushes = 0; pops = 0; removes = 0; fulls = 0; empties = 0;
		q_fill = 0;
		rank_reg = 8'h0;
		window_reg = troq_pkg::WINDOW_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_configs();
		test_random(1500);
		drain();
		$display("Ran %0d items: %0d push, %0d pop, %0d remove; %0d full drops, %0d empty pops",
			items_sent, pushes, pops, removes, fulls, empties);
		$display("Register settings swept including window 0, 16 and 31.");
		if (errors == 0 && expected_rsp.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
